/* src/tmed_pkg.sv */
// ----------------------------------------------------------------------------
// tmed_pkg
// shared field widths and controller state type for the temporal median unit
// ----------------------------------------------------------------------------
package tmed_pkg;

   // fixed port field widths
   localparam int VALUE_BITS = 12;
   localparam int INDEX_BITS = 6;
   localparam int COUNT_BITS = 5;
   localparam int CFG_BITS   = 5;

   // controller states, one-hot
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_LOAD   = 4'b0010,
      ST_SELECT = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

endpackage

/* src/temporal_median_per_pixel_unit.sv */
// ----------------------------------------------------------------------------
// temporal_median_per_pixel_unit
// per-pixel sliding-window temporal median over a ring of frame slots
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  req_      in         req_valid / req_stall  pixel_value, pixel_index
//  rsp_      out        rsp_valid / rsp_stall  median_value, median_index,
//                                              samples_used
//  csr_      in         csr_valid / csr_ready  window_len
//
//  one item at a time: the new sample enters the lanes directly, one history
//  read per cycle fetches each older sample of the window, then a bit-serial
//  radix select resolves one sample bit per cycle; the result then waits
//  until the output register is free.
//  a finished result sits in the output register while the next item is taken.
//  synchronous active-high reset clears control state; history memory is not
//  cleared and needs no sweep after reset.
//  csr_ready is high only while no item is at work; a pending register write
//  holds off the next item.
//
module temporal_median_per_pixel_unit
   import tmed_pkg::*;
#(
   parameter int WINDOW_MAX  = 16,
   parameter int GRID_SIDE   = 8,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [VALUE_BITS-1:0] req_pixel_value,
   input  logic [INDEX_BITS-1:0] req_pixel_index,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [VALUE_BITS-1:0] rsp_median_value,
   output logic [INDEX_BITS-1:0] rsp_median_index,
   output logic [COUNT_BITS-1:0] rsp_samples_used,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CFG_BITS-1:0]   csr_window_len
);

   localparam int NUM_PIX   = GRID_SIDE * GRID_SIDE;
   localparam int DEPTH     = WINDOW_MAX * NUM_PIX;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int SLOT_W    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CNT_W     = $clog2(WINDOW_MAX + 1);
   localparam int BIT_W     = $clog2(SAMPLE_BITS);
   localparam int WIN_RESET = (WINDOW_MAX < 16) ? WINDOW_MAX : 16;

   localparam logic [ADDR_W-1:0] PIX_STEP  = ADDR_W'(NUM_PIX);
   localparam logic [ADDR_W-1:0] LAST_BASE = ADDR_W'((WINDOW_MAX - 1) * NUM_PIX);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_MAX - 1);

   // population count over the lane flags
   function automatic logic [CNT_W-1:0] count_ones(input logic [WINDOW_MAX-1:0] v);
      logic [CNT_W-1:0] sum;
      sum = '0;
      for (int i = 0; i < WINDOW_MAX; i++) begin
         sum = sum + CNT_W'(v[i]);
      end
      return sum;
   endfunction

   // control and ring state
   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         window_len_ff, window_len_in;
   logic [CNT_W-1:0]         frames_filled_ff, frames_filled_in;
   logic [SLOT_W-1:0]        ring_slot_ff, ring_slot_in;
   logic [ADDR_W-1:0]        frame_base_ff, frame_base_in;

   // item under work
   logic [INDEX_BITS-1:0]    pix_ff, pix_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         remain_ff, remain_in;
   logic [ADDR_W-1:0]        rd_base_ff, rd_base_in;
   logic                     rd_valid_ff, rd_valid_in;
   logic [SAMPLE_BITS-1:0]   rd_data_ff;

   // sample lanes and radix select
   logic [SAMPLE_BITS-1:0]   lane_ff [WINDOW_MAX];
   logic [SAMPLE_BITS-1:0]   lane_in [WINDOW_MAX];
   logic [WINDOW_MAX-1:0]    mask_lo_ff, mask_lo_in, mask_hi_ff, mask_hi_in;
   logic [CNT_W-1:0]         rank_lo_ff, rank_lo_in, rank_hi_ff, rank_hi_in;
   logic [SAMPLE_BITS-1:0]   res_lo_ff, res_lo_in, res_hi_ff, res_hi_in;
   logic [BIT_W-1:0]         bit_cnt_ff, bit_cnt_in;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0]    rsp_value_ff, rsp_value_in;
   logic [INDEX_BITS-1:0]    rsp_index_ff, rsp_index_in;
   logic [COUNT_BITS-1:0]    rsp_used_ff, rsp_used_in;

   // history memory
   logic [SAMPLE_BITS-1:0]   history_mem [DEPTH];

   // combinational helpers
   logic [INDEX_BITS-1:0]    wrap_lut [2**INDEX_BITS];
   logic                     req_accept;
   logic                     csr_write;
   logic [INDEX_BITS-1:0]    pix_wrap;
   logic [SAMPLE_BITS-1:0]   sample;
   logic [ADDR_W-1:0]        wr_addr;
   logic [ADDR_W-1:0]        rd_addr;
   logic                     rd_issue;
   logic [CNT_W:0]           filled_p1;
   logic [CNT_W-1:0]         cfg_clamped;
   logic                     frame_end;
   logic [WINDOW_MAX-1:0]    msb;
   logic [CNT_W-1:0]         zeros_lo, zeros_hi;
   logic                     bit_lo, bit_hi;
   logic [SAMPLE_BITS:0]     mid_sum;
   logic                     out_free;

   // index wrap table, one entry per possible index code
   for (genvar g = 0; g < 2**INDEX_BITS; g++) begin : g_wrap
      assign wrap_lut[g] = INDEX_BITS'(g % NUM_PIX);
   end

   // handshakes, a pending register write goes ahead of the next item
   assign req_stall  = (state_ff != ST_IDLE) || csr_valid;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = (state_ff == ST_IDLE);
   assign csr_write  = csr_valid && csr_ready;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // input decode
   assign pix_wrap  = wrap_lut[req_pixel_index];
   assign sample    = SAMPLE_BITS'(req_pixel_value);
   assign wr_addr   = frame_base_ff + ADDR_W'(pix_wrap);
   assign rd_addr   = rd_base_ff + ADDR_W'(pix_ff);
   assign rd_issue  = (state_ff == ST_LOAD) && (remain_ff != '0);
   assign filled_p1 = {1'b0, frames_filled_ff} + (CNT_W + 1)'(1);
   assign frame_end = (32'(pix_wrap) == 32'(NUM_PIX - 1));

   // window length clamp
   always_comb begin
      if (csr_window_len == '0) begin
         cfg_clamped = CNT_W'(1);
      end else if (32'(csr_window_len) > 32'(WINDOW_MAX)) begin
         cfg_clamped = CNT_W'(WINDOW_MAX);
      end else begin
         cfg_clamped = CNT_W'(csr_window_len);
      end
   end

   // top bit of every lane and per-rank zero counts
   always_comb begin
      for (int i = 0; i < WINDOW_MAX; i++) begin
         msb[i] = lane_ff[i][SAMPLE_BITS-1];
      end
      zeros_lo = count_ones(mask_lo_ff & ~msb);
      zeros_hi = count_ones(mask_hi_ff & ~msb);
      bit_lo   = (rank_lo_ff >= zeros_lo);
      bit_hi   = (rank_hi_ff >= zeros_hi);
      mid_sum  = {1'b0, res_lo_ff} + {1'b0, res_hi_ff};
   end

   // next-state logic
   always_comb begin
      state_in         = state_ff;
      window_len_in    = window_len_ff;
      frames_filled_in = frames_filled_ff;
      ring_slot_in     = ring_slot_ff;
      frame_base_in    = frame_base_ff;
      pix_in           = pix_ff;
      count_in         = count_ff;
      remain_in        = remain_ff;
      rd_base_in       = rd_base_ff;
      rd_valid_in      = rd_issue;
      lane_in          = lane_ff;
      mask_lo_in       = mask_lo_ff;
      mask_hi_in       = mask_hi_ff;
      rank_lo_in       = rank_lo_ff;
      rank_hi_in       = rank_hi_ff;
      res_lo_in        = res_lo_ff;
      res_hi_in        = res_hi_ff;
      bit_cnt_in       = bit_cnt_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_value_in     = rsp_value_ff;
      rsp_index_in     = rsp_index_ff;
      rsp_used_in      = rsp_used_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               // samples in the window, new one included
               if (filled_p1 > {1'b0, window_len_ff}) begin
                  count_in = window_len_ff;
               end else begin
                  count_in = filled_p1[CNT_W-1:0];
               end
               pix_in     = pix_wrap;
               remain_in  = count_in - CNT_W'(1);
               rank_lo_in = (count_in - CNT_W'(1)) >> 1;
               rank_hi_in = count_in >> 1;
               for (int i = 0; i < WINDOW_MAX; i++) begin
                  mask_lo_in[i] = (32'(i) < 32'(count_in));
               end
               mask_hi_in = mask_lo_in;
               // older frames start one slot back
               rd_base_in = (frame_base_ff == '0) ? LAST_BASE : frame_base_ff - PIX_STEP;
               // new sample enters the lanes directly
               lane_in[0] = sample;
               for (int i = 1; i < WINDOW_MAX; i++) begin
                  lane_in[i] = lane_ff[i-1];
               end
               // frame bookkeeping
               if (frame_end) begin
                  ring_slot_in  = (ring_slot_ff == LAST_SLOT) ? '0 : ring_slot_ff + SLOT_W'(1);
                  frame_base_in = (ring_slot_ff == LAST_SLOT) ? '0 : frame_base_ff + PIX_STEP;
                  if (frames_filled_ff < window_len_ff) begin
                     frames_filled_in = frames_filled_ff + CNT_W'(1);
                  end
               end
               state_in = ST_LOAD;
            end
         end

         ST_LOAD: begin
            // walk back one slot per read
            if (rd_issue) begin
               remain_in  = remain_ff - CNT_W'(1);
               rd_base_in = (rd_base_ff == '0) ? LAST_BASE : rd_base_ff - PIX_STEP;
            end
            // read data enters the lanes
            if (rd_valid_ff) begin
               lane_in[0] = rd_data_ff;
               for (int i = 1; i < WINDOW_MAX; i++) begin
                  lane_in[i] = lane_ff[i-1];
               end
            end
            if ((remain_ff == '0) && !rd_valid_ff) begin
               bit_cnt_in = BIT_W'(SAMPLE_BITS - 1);
               state_in   = ST_SELECT;
            end
         end

         ST_SELECT: begin
            // lower middle rank
            if (bit_lo) begin
               rank_lo_in = rank_lo_ff - zeros_lo;
               mask_lo_in = mask_lo_ff & msb;
            end else begin
               mask_lo_in = mask_lo_ff & ~msb;
            end
            // upper middle rank
            if (bit_hi) begin
               rank_hi_in = rank_hi_ff - zeros_hi;
               mask_hi_in = mask_hi_ff & msb;
            end else begin
               mask_hi_in = mask_hi_ff & ~msb;
            end
            res_lo_in = {res_lo_ff[SAMPLE_BITS-2:0], bit_lo};
            res_hi_in = {res_hi_ff[SAMPLE_BITS-2:0], bit_hi};
            // next bit moves to the top of each lane
            for (int i = 0; i < WINDOW_MAX; i++) begin
               lane_in[i] = {lane_ff[i][SAMPLE_BITS-2:0], 1'b0};
            end
            if (bit_cnt_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               bit_cnt_in = bit_cnt_ff - BIT_W'(1);
            end
         end

         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = VALUE_BITS'(mid_sum[SAMPLE_BITS:1]);
               rsp_index_in = pix_ff;
               rsp_used_in  = COUNT_BITS'(count_ff);
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // register write restarts the fill
      if (csr_write) begin
         window_len_in    = cfg_clamped;
         frames_filled_in = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         window_len_ff    <= CNT_W'(WIN_RESET);
         frames_filled_ff <= '0;
         ring_slot_ff     <= '0;
         frame_base_ff    <= '0;
         rd_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         window_len_ff    <= window_len_in;
         frames_filled_ff <= frames_filled_in;
         ring_slot_ff     <= ring_slot_in;
         frame_base_ff    <= frame_base_in;
         rd_valid_ff      <= rd_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pix_ff       <= pix_in;
      count_ff     <= count_in;
      remain_ff    <= remain_in;
      rd_base_ff   <= rd_base_in;
      lane_ff      <= lane_in;
      mask_lo_ff   <= mask_lo_in;
      mask_hi_ff   <= mask_hi_in;
      rank_lo_ff   <= rank_lo_in;
      rank_hi_ff   <= rank_hi_in;
      res_lo_ff    <= res_lo_in;
      res_hi_ff    <= res_hi_in;
      bit_cnt_ff   <= bit_cnt_in;
      rsp_value_ff <= rsp_value_in;
      rsp_index_ff <= rsp_index_in;
      rsp_used_ff  <= rsp_used_in;
   end

   // history memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (req_accept) begin
         history_mem[wr_addr] <= sample;
      end
      if (rd_issue) begin
         rd_data_ff <= history_mem[rd_addr];
      end
   end

   // outputs
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_median_value = rsp_value_ff;
   assign rsp_median_index = rsp_index_ff;
   assign rsp_samples_used = rsp_used_ff;

endmodule

/* dv/tb_temporal_median_per_pixel_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_temporal_median_per_pixel_unit
// streams pixel frames into the temporal median unit under random valid and
// stall gaps, predicts each per-pixel median from a shadow history ring and
// compares every result field; window length is changed between phases
// ----------------------------------------------------------------------------
module tb_temporal_median_per_pixel_unit;
   import tmed_pkg::*;

   localparam int WINDOW_MAX  = 16;
   localparam int PIXELS      = 64;
   localparam int LAST_PIXEL  = PIXELS - 1;
   localparam int ITEM_TARGET = 1650;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_START  = 3000;
   localparam int HOLD_CYCLES = 400;
   localparam int QUIET_FROM  = 12000;
   localparam int QUIET_TO    = 20000;
   localparam int DRAIN_WAIT  = 64;

   // sample spread used when building frames
   localparam int SPREAD_WIDE    = 0;
   localparam int SPREAD_NARROW  = 1;
   localparam int SPREAD_EXTREME = 2;

   typedef struct {
      logic [VALUE_BITS-1:0] value;
      logic [INDEX_BITS-1:0] index;
   } pixel_item_type;

   typedef struct {
      logic [VALUE_BITS-1:0] value;
      logic [INDEX_BITS-1:0] index;
      logic [COUNT_BITS-1:0] used;
   } median_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [VALUE_BITS-1:0] req_pixel_value = '0;
   logic [INDEX_BITS-1:0] req_pixel_index = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [VALUE_BITS-1:0] rsp_median_value;
   logic [INDEX_BITS-1:0] rsp_median_index;
   logic [COUNT_BITS-1:0] rsp_samples_used;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CFG_BITS-1:0]   csr_window_len = '0;

   pixel_item_type pixel_q[$];
   median_type     median_q[$];

   int unsigned cycle_count  = 0;
   int unsigned hold_left    = 0;
   int unsigned items_pushed = 0;
   int unsigned results_seen = 0;
   int unsigned error_count  = 0;

   // shadow of the block state
   logic [VALUE_BITS-1:0] history [WINDOW_MAX][PIXELS];
   logic [3:0]            ring_pos    = '0;
   int unsigned           frames_done = 0;
   int unsigned           win_len     = WINDOW_MAX;

   median_type want;

   temporal_median_per_pixel_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel_value  (req_pixel_value),
      .req_pixel_index  (req_pixel_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_median_value (rsp_median_value),
      .rsp_median_index (rsp_median_index),
      .rsp_samples_used (rsp_samples_used),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_window_len   (csr_window_len)
   );

   // clock
   always #5 clock = ~clock;

   // cycle count and timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_temporal_median_per_pixel_unit: errors");
         $finish;
      end
   end

   function automatic bit roll_idle();
      if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO)
         return 1'b0;
      return $urandom_range(0, 99) < 9;
   endfunction

   task automatic log_error(input string msg);
      error_count++;
      if (error_count <= 10)
         $display("ERROR at cycle %0d: %s", cycle_count, msg);
   endtask

   // shadow update for one accepted pixel, queues the expected median
   task automatic predict_median(input logic [VALUE_BITS-1:0] sample,
                                 input logic [INDEX_BITS-1:0] pix);
      logic [VALUE_BITS-1:0] taps [WINDOW_MAX];
      logic [VALUE_BITS-1:0] swap;
      logic [VALUE_BITS:0]   pair_sum;
      int unsigned           depth;
      median_type            m;
      history[ring_pos][pix] = sample;
      depth = frames_done + 1;
      if (depth > win_len)
         depth = win_len;
      // newest first, walking back through the ring
      for (int k = 0; k < depth; k++)
         taps[k] = history[(ring_pos + WINDOW_MAX - k) % WINDOW_MAX][pix];
      for (int i = 0; i < depth; i++)
         for (int j = 0; j + 1 < depth - i; j++)
            if (taps[j] > taps[j+1]) begin
               swap      = taps[j];
               taps[j]   = taps[j+1];
               taps[j+1] = swap;
            end
      // even count takes the floor of the mean of the two middle samples
      if (depth % 2 == 0) begin
         pair_sum = taps[depth/2 - 1] + taps[depth/2];
         m.value  = pair_sum[VALUE_BITS:1];
      end else begin
         m.value = taps[depth/2];
      end
      m.index = pix;
      m.used  = COUNT_BITS'(depth);
      median_q.push_back(m);
      // last pixel closes the frame
      if (pix == LAST_PIXEL) begin
         ring_pos = ring_pos + 1'b1;
         if (frames_done < win_len)
            frames_done++;
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            predict_median(req_pixel_value, req_pixel_index);
         if (!req_valid || !req_stall) begin
            if (pixel_q.size() != 0 && !roll_idle()) begin
               req_valid       <= 1'b1;
               req_pixel_value <= pixel_q[0].value;
               req_pixel_index <= pixel_q[0].index;
               void'(pixel_q.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (reset)
         hold_left <= 0;
      else if (cycle_count == HOLD_START)
         hold_left <= HOLD_CYCLES;
      else if (hold_left != 0)
         hold_left <= hold_left - 1;
   end

   // response stall
   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= (hold_left != 0) || roll_idle();
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (median_q.size() == 0) begin
            log_error($sformatf("median with none expected: value %0d index %0d used %0d",
                                rsp_median_value, rsp_median_index, rsp_samples_used));
         end else begin
            want = median_q.pop_front();
            if (rsp_median_value !== want.value || rsp_median_index !== want.index ||
                rsp_samples_used !== want.used)
               log_error($sformatf("median exp %0d/%0d/%0d got %0d/%0d/%0d (value/index/used)",
                                   want.value, want.index, want.used, rsp_median_value,
                                   rsp_median_index, rsp_samples_used));
         end
      end
   end

   task automatic push_pixel(input int unsigned value, input int unsigned index);
      pixel_item_type item;
      item.value = VALUE_BITS'(value);
      item.index = INDEX_BITS'(index);
      pixel_q.push_back(item);
      items_pushed++;
   endtask

   function automatic int unsigned pick_sample(input int spread);
      case (spread)
         SPREAD_NARROW:  return 12'h7F8 + $urandom_range(0, 7);
         SPREAD_EXTREME: return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
         default:        return $urandom_range(0, 4095);
      endcase
   endfunction

   function automatic int pick_spread();
      int unsigned roll;
      roll = $urandom_range(0, 5);
      if (roll == 4)
         return SPREAD_NARROW;
      if (roll == 5)
         return SPREAD_EXTREME;
      return SPREAD_WIDE;
   endfunction

   task automatic push_frame();
      int spread;
      spread = pick_spread();
      for (int p = 0; p < PIXELS; p++)
         push_pixel(pick_sample(spread), p);
   endtask

   task automatic wait_drained();
      while (results_seen < items_pushed)
         @(posedge clock);
   endtask

   // window length write, only once every median is back
   task automatic write_window(input logic [CFG_BITS-1:0] len);
      wait_drained();
      @(posedge clock);
      csr_valid      <= 1'b1;
      csr_window_len <= len;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      if (len == 0)
         win_len = 1;
      else if (len > WINDOW_MAX)
         win_len = WINDOW_MAX;
      else
         win_len = len;
      frames_done = 0;
   endtask

   initial begin
      logic [CFG_BITS-1:0] phase_lens [5];
      int                  phase;
      phase_lens = '{5'd1, 5'd31, 5'd2, 5'd17, 5'd16};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, even and odd counts, growing window
      push_pixel(0, 0);
      push_pixel(4095, 1);
      push_pixel(12'hAAA, 2);
      push_pixel(12'h555, 3);
      push_pixel(2048, 62);
      push_pixel(4095, LAST_PIXEL);
      push_pixel(4095, 0);
      push_pixel(4094, 1);
      push_pixel(12'h555, 2);
      push_pixel(12'h555, 3);
      push_pixel(7, LAST_PIXEL);
      push_pixel(2000, 0);
      push_pixel(9, 1);
      push_pixel(100, LAST_PIXEL);
      push_pixel(1, 0);

      // zero window length behaves as one
      write_window(5'd0);
      push_pixel(4095, 17);
      push_pixel(0, LAST_PIXEL);
      push_pixel(12'hAAA, 40);

      // oversize window saturates; full frames fill every ring slot
      write_window(5'd31);
      repeat (WINDOW_MAX) push_frame();

      // random phases: mostly whole frames, some scattered pixels
      phase = 0;
      while (items_pushed < ITEM_TARGET) begin
         if (phase < 5)
            write_window(phase_lens[phase]);
         else
            write_window(CFG_BITS'($urandom_range(0, 31)));
         phase++;
         repeat ($urandom_range(3, 6)) begin
            if (items_pushed < ITEM_TARGET) begin
               if ($urandom_range(0, 3) != 0) begin
                  push_frame();
               end else begin
                  repeat ($urandom_range(4, 40))
                     push_pixel($urandom_range(0, 4095), $urandom_range(0, LAST_PIXEL));
               end
            end
         end
      end

      // drain and settle
      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (median_q.size() != 0)
         log_error($sformatf("%0d medians never arrived", median_q.size()));
      if (error_count == 0)
         $display("tb_temporal_median_per_pixel_unit: clean");
      else
         $display("tb_temporal_median_per_pixel_unit: errors");
      $finish;
   end

endmodule
